>>> rtl/core/assert_macros.svh
// assertion helpers used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every clock edge outside reset
`define CHK_ASSERT(name, clk, rst_n, prop) \
  name: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("%m: assertion failed");

// condition must never be seen outside reset
`define CHK_NEVER(name, clk, rst_n, cond) \
  name: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error("%m: forbidden condition seen");

`endif

>>> rtl/core/skdht_pkg.sv
package skdht_pkg;

  localparam int TABLE_SLOTS = 64;
  localparam int MAX_KEY_LEN = 64;

  localparam int SLOT_W  = $clog2(TABLE_SLOTS);
  localparam int IDX_W   = $clog2(MAX_KEY_LEN);
  localparam int LEN_W   = $clog2(MAX_KEY_LEN + 1);
  localparam int PROBE_W = $clog2(TABLE_SLOTS + 1);
  localparam int KEYS_DEPTH = TABLE_SLOTS * MAX_KEY_LEN;

  localparam logic [31:0] HASH_TOP = 32'hf000_0000;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_NOT_FOUND = 2'd1;
  localparam logic [1:0] ST_FULL      = 2'd2;
  localparam logic [1:0] ST_TOO_LONG  = 2'd3;

  localparam logic OP_LOOKUP = 1'b0;
  localparam logic OP_INSERT = 1'b1;

  typedef struct packed {
    logic        op;
    logic [7:0]  key_byte;
    logic        key_last;
    logic [31:0] entry_value;
  } req_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [31:0] found_value;
    logic [5:0]  slot_index;
  } rsp_t;

endpackage

>>> rtl/core/skdht_ram.sv
module skdht_ram #(
  parameter int Width = 8,
  parameter int Depth = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] addr_i,
  input  logic [Width-1:0]         wdata_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_o <= mem_q[addr_i];
  end

endmodule

>>> rtl/core/string_key_double_hash_table.sv
// channel   | ports                     | handshake
// ----------+---------------------------+-------------------------------
// request   | start, busy, req_i        | beat taken when start & !busy
// result    | rsp_valid_o, rsp_o        | one-cycle strobe, no stall
//
// a key byte that is not the last one is taken while idle and leaves busy low.
// a last byte goes to a decide state, then probes slot by slot: an insert skips used slots and
// claims a free one; a lookup stops at an empty slot, checks the stored length of a used one,
// then compares the key byte by byte; an insert copies its key byte by byte (single-port key memories).
// reset clears the used bits, entry count and the incoming key state.
// busy is high from the cycle after a last byte until the strobe; the receiver can't stall
module string_key_double_hash_table
  import skdht_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic start,
  input  req_t req_i,
  output logic busy,
  output logic rsp_valid_o,
  output rsp_t rsp_o
);

  typedef enum logic [2:0] {
    S_IDLE, S_DECIDE, S_PROBE, S_LEN_CHK, S_CMP_RD, S_CMP_CHK, S_CPY_RD, S_CPY_WR
  } state_e;

  state_e state_q;
  logic [LEN_W-1:0]       len_q;
  logic                   ovf_q;
  logic                   op_q;
  logic [31:0]            hash_q;
  logic [31:0]            val_q;
  logic [SLOT_W-1:0]      pos_q;
  logic [SLOT_W-1:0]      step_q;
  logic [PROBE_W-1:0]     probes_q;
  logic [IDX_W-1:0]       idx_q;
  logic [SLOT_W-1:0]      cnt_q;
  logic [TABLE_SLOTS-1:0] used_q;
  logic                   rsp_valid_q;
  rsp_t                   rsp_q;

  logic [31:0] hash_sh, hash_top, hash_new;
  logic        accept;

  assign accept   = start && (state_q == S_IDLE);
  assign hash_sh  = {hash_q[27:0], 4'b0} + 32'(req_i.key_byte);
  assign hash_top = hash_sh & HASH_TOP;
  assign hash_new = (hash_top != '0) ? (hash_sh ^ (hash_top >> 24) ^ hash_top) : hash_sh;

  // incoming key buffer
  logic             ikey_we;
  logic [IDX_W-1:0] ikey_addr;
  logic [7:0]       ikey_rdata;
  assign ikey_we   = accept && (len_q < LEN_W'(MAX_KEY_LEN));
  assign ikey_addr = (state_q == S_IDLE) ? len_q[IDX_W-1:0] : idx_q;

  skdht_ram #(.Width(8), .Depth(MAX_KEY_LEN)) u_ikey (
    .clk_i, .we_i(ikey_we), .addr_i(ikey_addr), .wdata_i(req_i.key_byte),
    .rdata_o(ikey_rdata)
  );

  // stored key bytes
  logic       skey_we;
  logic [7:0] skey_rdata;
  assign skey_we = (state_q == S_CPY_WR);

  skdht_ram #(.Width(8), .Depth(KEYS_DEPTH)) u_skey (
    .clk_i, .we_i(skey_we), .addr_i({pos_q, idx_q}), .wdata_i(ikey_rdata),
    .rdata_o(skey_rdata)
  );

  // per-slot length and payload, written when a slot is claimed
  logic             claim;
  logic [LEN_W-1:0] klen_rdata;
  logic [31:0]      pay_rdata;
  assign claim = (state_q == S_PROBE) && (probes_q != PROBE_W'(TABLE_SLOTS)) &&
                 !used_q[pos_q] && (op_q == OP_INSERT);

  skdht_ram #(.Width(LEN_W), .Depth(TABLE_SLOTS)) u_klen (
    .clk_i, .we_i(claim), .addr_i(pos_q), .wdata_i(len_q), .rdata_o(klen_rdata)
  );

  skdht_ram #(.Width(32), .Depth(TABLE_SLOTS)) u_pay (
    .clk_i, .we_i(claim), .addr_i(pos_q), .wdata_i(val_q), .rdata_o(pay_rdata)
  );

  // every finishing branch also clears the incoming key state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      len_q       <= '0;
      ovf_q       <= 1'b0;
      op_q        <= OP_LOOKUP;
      hash_q      <= '0;
      cnt_q       <= '0;
      used_q      <= '0;
      rsp_valid_q <= 1'b0;
      rsp_q       <= '0;
      val_q       <= '0;
      pos_q       <= '0;
      step_q      <= '0;
      probes_q    <= '0;
      idx_q       <= '0;
    end else begin
      rsp_valid_q <= 1'b0;
      case (state_q)
        S_IDLE: begin
          if (accept) begin
            if (len_q == '0 && !ovf_q) begin
              op_q <= req_i.op;
            end
            if (len_q < LEN_W'(MAX_KEY_LEN)) begin
              len_q  <= len_q + 1'b1;
              hash_q <= hash_new;
            end else begin
              ovf_q <= 1'b1;
            end
            val_q <= req_i.entry_value;
            if (req_i.key_last) begin
              state_q <= S_DECIDE;
            end
          end
        end
        S_DECIDE: begin
          pos_q    <= hash_q[SLOT_W-1:0];
          step_q   <= {hash_q[2*SLOT_W-2:SLOT_W], 1'b1};
          probes_q <= '0;
          if (ovf_q) begin
            rsp_q       <= '{status: ST_TOO_LONG, found_value: '0, slot_index: '0};
            rsp_valid_q <= 1'b1;
            state_q     <= S_IDLE;
            len_q       <= '0;
            hash_q      <= '0;
            ovf_q       <= 1'b0;
          end else if (op_q == OP_INSERT && (int'(cnt_q) + 2) >= TABLE_SLOTS) begin
            rsp_q       <= '{status: ST_FULL, found_value: '0, slot_index: '0};
            rsp_valid_q <= 1'b1;
            state_q     <= S_IDLE;
            len_q       <= '0;
            hash_q      <= '0;
            ovf_q       <= 1'b0;
          end else begin
            state_q <= S_PROBE;
          end
        end
        S_PROBE: begin
          idx_q <= '0;
          if (probes_q == PROBE_W'(TABLE_SLOTS) || (!used_q[pos_q] && op_q == OP_LOOKUP)) begin
            rsp_q       <= '{status: (op_q == OP_INSERT) ? ST_FULL : ST_NOT_FOUND,
                             found_value: '0, slot_index: '0};
            rsp_valid_q <= 1'b1;
            state_q     <= S_IDLE;
            len_q       <= '0;
            hash_q      <= '0;
            ovf_q       <= 1'b0;
          end else if (claim) begin
            used_q[pos_q] <= 1'b1;
            cnt_q         <= cnt_q + 1'b1;
            state_q       <= S_CPY_RD;
          end else if (op_q == OP_INSERT) begin
            pos_q    <= pos_q + step_q;
            probes_q <= probes_q + 1'b1;
          end else begin
            state_q <= S_LEN_CHK;
          end
        end
        S_LEN_CHK: begin
          if (klen_rdata != len_q) begin
            pos_q    <= pos_q + step_q;
            probes_q <= probes_q + 1'b1;
            state_q  <= S_PROBE;
          end else begin
            state_q <= S_CMP_RD;
          end
        end
        S_CMP_RD: begin
          state_q <= S_CMP_CHK;
        end
        S_CMP_CHK: begin
          if (skey_rdata != ikey_rdata) begin
            pos_q    <= pos_q + step_q;
            probes_q <= probes_q + 1'b1;
            state_q  <= S_PROBE;
          end else if (LEN_W'(idx_q) + 1'b1 == len_q) begin
            rsp_q       <= '{status: ST_OK, found_value: pay_rdata, slot_index: pos_q};
            rsp_valid_q <= 1'b1;
            state_q     <= S_IDLE;
            len_q       <= '0;
            hash_q      <= '0;
            ovf_q       <= 1'b0;
          end else begin
            idx_q   <= idx_q + 1'b1;
            state_q <= S_CMP_RD;
          end
        end
        S_CPY_RD: begin
          state_q <= S_CPY_WR;
        end
        S_CPY_WR: begin
          if (LEN_W'(idx_q) + 1'b1 == len_q) begin
            rsp_q       <= '{status: ST_OK, found_value: '0, slot_index: pos_q};
            rsp_valid_q <= 1'b1;
            state_q     <= S_IDLE;
            len_q       <= '0;
            hash_q      <= '0;
            ovf_q       <= 1'b0;
          end else begin
            idx_q   <= idx_q + 1'b1;
            state_q <= S_CPY_RD;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign busy        = (state_q != S_IDLE);
  assign rsp_valid_o = rsp_valid_q;
  assign rsp_o       = rsp_q;

endmodule

>>> rtl/core/skdht_checker.sv
module skdht_checker
  import skdht_pkg::*;
(
  input logic clk_i,
  input logic rst_ni,
  input logic start,
  input req_t req_i,
  input logic busy,
  input logic rsp_valid_o,
  input rsp_t rsp_o
);

  `include "assert_macros.svh"

  // a beat that is not the last byte of a key yields no result
  `CHK_ASSERT(a_no_rsp_mid_key, clk_i, rst_ni, start && !busy && !req_i.key_last |=> !rsp_valid_o)

  // a last byte always starts a busy period
  `CHK_ASSERT(a_last_busy, clk_i, rst_ni, start && !busy && req_i.key_last |=> busy)

  // value only travels with a successful answer
  `CHK_NEVER(a_value_zero, clk_i, rst_ni, rsp_valid_o && rsp_o.status != ST_OK && rsp_o.found_value != '0)

  // a result ends the busy period
  `CHK_NEVER(a_rsp_not_busy, clk_i, rst_ni, rsp_valid_o && busy)

endmodule

bind string_key_double_hash_table skdht_checker u_skdht_checker (
  .clk_i(clk_i), .rst_ni(rst_ni), .start(start), .req_i(req_i), .busy(busy),
  .rsp_valid_o(rsp_valid_o), .rsp_o(rsp_o)
);
